// ----- design/dfr_pkg.sv -----
// Package for the flag/CRC-8 packet deframer.
// Holds header layout constants, register indexes, state codes and the CRC-8 byte update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfr_pkg;

  localparam int HDR_BYTES = 15;
  localparam int CRC_BYTES = HDR_BYTES - 1;

  localparam logic [7:0] CRC_INIT = 8'h77;
  localparam logic [7:0] CRC_POLY = 8'h8c;

  localparam logic REG_START_FLAG = 1'b0;
  localparam logic REG_BODY_LIMIT = 1'b1;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CRC  = 3'b010,
    S_DONE = 3'b100
  } dfr_state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } crc_ctl_t;

  // reflected CRC-8, one byte: eight shift/xor steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/dfr_crc_unit.sv -----
// Shared CRC-8 accumulator: one header byte folded in per step.
// Depends on dfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfr_crc_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dfr_pkg::crc_ctl_t ctl,
  input  wire logic [7:0]      data,
  output logic [7:0]           crc
);
  import dfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_INIT;
    end else if (ctl.clear) begin
      crc <= CRC_INIT;
    end else if (ctl.step) begin
      crc <= crc8_update(crc, data);
    end
  end

endmodule
`default_nettype wire

// ----- design/crc_checked_packet_deframer_top.sv -----
// Flag/CRC-8 packet deframer top: header window, sequencer, output register.
// A byte that completes a flagged window starts a header check: it is accepted, then 14 CRC
// steps run through the shared unit, then S_DONE checks the CRC and loads the output register.
// Body bytes pass at one per cycle while the output register is free; input stalls during a check.
// Reset (synchronous, rst high): window empty, hunting, no result pending, registers to
// start_flag 0 and body_limit 65535.
`timescale 1ns / 1ps
`default_nettype none
module crc_checked_packet_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [31:0]      command,
  output logic [31:0]      sequence_res,
  output logic             push_res,
  output logic [15:0]      body_len,
  output logic [7:0]       body_byte,
  output logic             last
);
  import dfr_pkg::*;

  localparam logic [3:0] FILL_FULL = 4'(HDR_BYTES);
  localparam logic [3:0] FILL_LAST = 4'(HDR_BYTES - 1);
  localparam logic [3:0] CNT_LAST  = 4'(CRC_BYTES - 1);

  logic [7:0]  start_flag;
  logic [15:0] body_limit;
  logic [7:0]  hdr_win [HDR_BYTES];
  logic [3:0]  win_fill;
  logic        in_body;
  logic [15:0] body_left;
  logic [3:0]  crc_cnt;
  dfr_state_t  state;

  logic        slot_free;
  logic        in_xfer;
  logic [7:0]  head_next;
  logic        will_check;
  crc_ctl_t    crc_ctl;
  logic [7:0]  crc;
  logic        crc_match;
  logic [31:0] blen;
  logic        blen_ok;
  logic        out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_flag <= 8'h00;
      body_limit <= 16'hffff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_FLAG: start_flag <= cfg_data[7:0];
        REG_BODY_LIMIT: body_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_free  = !out_valid || !out_stall;
    in_stall   = !((state == S_IDLE) && slot_free);
    in_xfer    = in_valid && !in_stall;
    head_next  = (win_fill == FILL_FULL) ? hdr_win[1] :
                 ((win_fill == 4'd0) ? in_byte : hdr_win[0]);
    will_check = !in_body && (win_fill >= FILL_LAST) && (head_next == start_flag);
    crc_ctl.clear = in_xfer && will_check;
    crc_ctl.step  = (state == S_CRC);
    crc_match  = (crc == hdr_win[HDR_BYTES-1]);
    blen       = {hdr_win[10], hdr_win[11], hdr_win[12], hdr_win[13]};
    blen_ok    = (blen[31:16] == 16'h0000) && (blen[15:0] <= body_limit);
    out_load   = ((state == S_IDLE) && in_xfer && in_body) ||
                 ((state == S_DONE) && crc_match && blen_ok);
  end

  dfr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (hdr_win[crc_cnt]),
    .crc  (crc)
  );

  // window storage
  always_ff @(posedge clk) begin
    if (in_xfer && !in_body) begin
      if (win_fill < FILL_FULL) begin
        hdr_win[win_fill] <= in_byte;
      end else begin
        for (int i = 0; i < HDR_BYTES - 1; i++) begin
          hdr_win[i] <= hdr_win[i+1];
        end
        hdr_win[HDR_BYTES-1] <= in_byte;
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win_fill  <= 4'd0;
      in_body   <= 1'b0;
      body_left <= 16'd0;
      crc_cnt   <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_body) begin
              kind         <= KIND_BODY;
              command      <= 32'd0;
              sequence_res <= 32'd0;
              push_res     <= 1'b0;
              body_len     <= 16'd0;
              body_byte    <= in_byte;
              last         <= (body_left <= 16'd1);
              if (body_left <= 16'd1) begin
                body_left <= 16'd0;
                in_body   <= 1'b0;
              end else begin
                body_left <= body_left - 16'd1;
              end
            end else begin
              if (win_fill < FILL_FULL) begin
                win_fill <= win_fill + 4'd1;
              end
              if (will_check) begin
                crc_cnt <= 4'd0;
                state   <= S_CRC;
              end
            end
          end
        end
        S_CRC: begin
          crc_cnt <= crc_cnt + 4'd1;
          if (crc_cnt == CNT_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
          if (crc_match) begin
            win_fill <= 4'd0;
            if (blen_ok) begin
              kind         <= KIND_HEADER;
              command      <= {hdr_win[1], hdr_win[2], hdr_win[3], hdr_win[4]};
              sequence_res <= {hdr_win[5], hdr_win[6], hdr_win[7], hdr_win[8]};
              push_res     <= (hdr_win[9] == 8'd1);
              body_len     <= blen[15:0];
              body_byte    <= 8'd0;
              last         <= (blen[15:0] == 16'd0);
              if (blen[15:0] != 16'd0) begin
                in_body   <= 1'b1;
                body_left <= blen[15:0];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/dfr_checker.sv -----
// Port-level checks for the packet deframer, bound to the top level.
// Depends on dfr_pkg and crc_checked_packet_deframer_top.
`timescale 1ns / 1ps
`default_nettype none
module dfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        kind,
  input wire logic [31:0] command,
  input wire logic [31:0] sequence_res,
  input wire logic        push_res,
  input wire logic [15:0] body_len,
  input wire logic [7:0]  body_byte,
  input wire logic        last
);
  import dfr_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(body_byte) && $stable(last))
    else $error("stalled result transfer changed");

  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_BODY) |->
      (command == 32'd0) && (sequence_res == 32'd0) && !push_res && (body_len == 16'd0))
    else $error("body transfer carries header fields");

  a_hdr_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_HEADER) |-> (body_byte == 8'd0))
    else $error("header transfer carries a body byte");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_HEADER) |-> (last == (body_len == 16'd0)))
    else $error("header last flag disagrees with body length");

endmodule

bind crc_checked_packet_deframer_top dfr_checker u_dfr_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for crc_checked_packet_deframer_top: framed byte streams with
// good, corrupted and oversized headers, checked against an in-bench deframer.
// Depends on dfr_pkg and the deframer RTL.
module tb_top;
  import dfr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 30;

  typedef struct packed {
    logic        kind;
    logic [31:0] command;
    logic [31:0] sequence_res;
    logic        push_res;
    logic [15:0] body_len;
    logic [7:0]  body_byte;
    logic        last;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_START_FLAG;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [31:0] command;
  logic [31:0] sequence_res;
  logic        push_res;
  logic [15:0] body_len;
  logic [7:0]  body_byte;
  logic        last;

  // in-bench deframer state
  logic [7:0]  win [HDR_BYTES];
  int          win_fill = 0;
  bit          body_on = 1'b0;
  logic [15:0] body_rem = '0;
  logic [7:0]  flag_cfg = 8'h00;
  logic [15:0] limit_cfg = 16'hffff;
  logic [7:0]  crc_lut [256];

  deframed_t   expected_items [$];
  logic [7:0]  stream_q [$];

  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit held = 1'b0;
  bit calm = 1'b0;
  int rx_count = 0;
  int errors = 0;
  int cycles = 0;

  crc_checked_packet_deframer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .command      (command),
    .sequence_res (sequence_res),
    .push_res     (push_res),
    .body_len     (body_len),
    .body_byte    (body_byte),
    .last         (last)
  );

  always #10 clk = ~clk;

  task automatic deframe_byte(input logic [7:0] b);
    deframed_t   r;
    logic [7:0]  c;
    logic [31:0] blen;
    r = '0;
    if (body_on) begin
      r.kind = KIND_BODY;
      r.body_byte = b;
      r.last = (body_rem <= 16'd1);
      if (body_rem <= 16'd1) begin
        body_rem = '0;
        body_on = 1'b0;
      end else begin
        body_rem = body_rem - 16'd1;
      end
      expected_items.push_back(r);
    end else begin
      if (win_fill < HDR_BYTES) begin
        win[win_fill] = b;
        win_fill++;
      end else begin
        for (int i = 0; i < HDR_BYTES - 1; i++) win[i] = win[i + 1];
        win[HDR_BYTES - 1] = b;
      end
      if (win_fill == HDR_BYTES && win[0] == flag_cfg) begin
        c = CRC_INIT;
        for (int i = 0; i < CRC_BYTES; i++) c = crc_lut[c ^ win[i]];
        if (c == win[HDR_BYTES - 1]) begin
          blen = {win[10], win[11], win[12], win[13]};
          win_fill = 0;
          if (blen <= {16'h0, limit_cfg}) begin
            r.kind = KIND_HEADER;
            r.command = {win[1], win[2], win[3], win[4]};
            r.sequence_res = {win[5], win[6], win[7], win[8]};
            r.push_res = (win[9] == 8'd1);
            r.body_len = blen[15:0];
            r.last = (blen == 32'd0);
            if (blen != 32'd0) begin
              body_on = 1'b1;
              body_rem = blen[15:0];
            end
            expected_items.push_back(r);
          end
        end
      end
    end
  endtask

  task automatic push_packet(input logic [31:0] cmd, input logic [31:0] seq,
                             input logic [7:0] push, input logic [31:0] len,
                             input bit bad_crc, input int n_body);
    logic [7:0] h [HDR_BYTES];
    logic [7:0] c;
    h[0] = flag_cfg;
    h[1] = cmd[31:24];
    h[2] = cmd[23:16];
    h[3] = cmd[15:8];
    h[4] = cmd[7:0];
    h[5] = seq[31:24];
    h[6] = seq[23:16];
    h[7] = seq[15:8];
    h[8] = seq[7:0];
    h[9] = push;
    h[10] = len[31:24];
    h[11] = len[23:16];
    h[12] = len[15:8];
    h[13] = len[7:0];
    c = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) c = crc_lut[c ^ h[i]];
    h[HDR_BYTES - 1] = bad_crc ? (c ^ (8'h01 << $urandom_range(0, 7))) : c;
    for (int i = 0; i < HDR_BYTES; i++) stream_q.push_back(h[i]);
    repeat (n_body) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_traffic(input int n_items);
    int          added;
    int          pick;
    int          nz;
    int          sel;
    logic [7:0]  pb;
    logic [31:0] len;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 19);
      sel = $urandom_range(0, 2);
      case (sel)
        0:       pb = 8'd0;
        1:       pb = 8'd1;
        default: pb = 8'($urandom_range(0, 255));
      endcase
      if (pick < 2) begin
        nz = $urandom_range(1, 6);
        repeat (nz) begin
          if ($urandom_range(0, 3) == 0) stream_q.push_back(flag_cfg);
          else stream_q.push_back(8'($urandom_range(0, 255)));
        end
        added += nz;
      end else if (pick < 4) begin
        push_packet($urandom, $urandom, pb, $urandom_range(0, 6), 1'b1, 0);
        added += HDR_BYTES;
      end else if (pick < 6) begin
        if (limit_cfg == 16'hffff || $urandom_range(0, 1) == 0) len = $urandom | 32'h0001_0000;
        else len = {16'h0, limit_cfg} + 32'd1 + $urandom_range(0, 5);
        nz = $urandom_range(0, 3);
        push_packet($urandom, $urandom, pb, len, 1'b0, nz);
        added += HDR_BYTES + nz;
      end else begin
        len = $urandom_range(0, 6);
        if ($urandom_range(0, 24) == 0) len = $urandom_range(7, 300);
        if (len > {16'h0, limit_cfg}) len = {16'h0, limit_cfg};
        push_packet($urandom, $urandom, pb, len, 1'b0, len);
        added += HDR_BYTES + len;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (stream_q.size() != 0 || in_valid || expected_items.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_FLAG) flag_cfg = val[7:0];
    else limit_cfg = val;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] flag, input logic [15:0] lim);
    logic [7:0] hi;
    hi = 8'($urandom_range(0, 255));
    write_reg(REG_START_FLAG, {hi, flag});
    write_reg(REG_BODY_LIMIT, lim);
  endtask

  // driver: one byte transfer per accepted cycle, random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_byte <= '0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) deframe_byte(in_byte);
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_valid <= 1'b1;
        in_byte <= stream_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks every result transfer, random stall bursts, one long hold
  always @(posedge clk) begin : mon
    deframed_t got;
    deframed_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind, command, sequence_res, push_res, body_len, body_byte, last};
        rx_count++;
        if (expected_items.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer: kind=%0d cmd=%h seq=%h push=%0d len=%0d byte=%h last=%0d",
                     got.kind, got.command, got.sequence_res, got.push_res, got.body_len,
                     got.body_byte, got.last);
        end else begin
          want = expected_items.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: kind=%0d cmd=%h seq=%h push=%0d len=%0d byte=%h last=%0d",
                       want.kind, want.command, want.sequence_res, want.push_res,
                       want.body_len, want.body_byte, want.last);
              $display("         got: kind=%0d cmd=%h seq=%h push=%0d len=%0d byte=%h last=%0d",
                       got.kind, got.command, got.sequence_res, got.push_res,
                       got.body_len, got.body_byte, got.last);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!held && rx_count >= HOLD_AT) begin
        held <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main
    logic [7:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 8'(i);
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      crc_lut[i] = c;
    end
    for (int i = 0; i < HDR_BYTES; i++) win[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: flag 0, length limit 65535
    push_packet(32'hffff_ffff, 32'hffff_ffff, 8'd1, 32'd0, 1'b0, 0);
    push_packet(32'h0, 32'h0, 8'hff, 32'd2, 1'b0, 2);
    wait_idle();

    set_regs(8'ha5, 16'd8);
    push_packet(32'h1234_5678, 32'h9abc_def0, 8'd0, 32'd9, 1'b0, 3);
    push_packet($urandom, $urandom, 8'd1, 32'd1, 1'b1, 2);
    push_packet($urandom, $urandom, 8'd2, 32'd8, 1'b0, 8);
    wait_idle();

    set_regs(8'ha5, 16'hffff);
    push_packet($urandom, $urandom, 8'd1, 32'd300, 1'b0, 300);
    random_traffic(120);
    wait_idle();

    set_regs(8'h00, 16'd0);
    random_traffic(130);
    wait_idle();

    set_regs(8'hff, 16'd3);
    random_traffic(130);
    wait_idle();

    calm = 1'b1;
    set_regs(8'($urandom_range(0, 255)), 16'($urandom_range(4, 40)));
    random_traffic(130);
    wait_idle();

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
